// ===== hw/rtl/kscs_pkg.sv =====
`timescale 1ns / 1ps

package kscs_pkg;

  // number of key bits taken into account
  localparam int KEY_COUNT = 32;
  // width of the input bitmap
  localparam int IN_BITS = 32;
  // key bits actually scanned (the bitmap never carries more than IN_BITS)
  localparam int SCAN_BITS = (KEY_COUNT < IN_BITS) ? KEY_COUNT : IN_BITS;
  // bit index width
  localparam int IDX_W = (SCAN_BITS > 1) ? $clog2(SCAN_BITS) : 1;
  // width of key number and group
  localparam int NUM_W = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REL,
    ST_PRS
  } state_t;

  // result of the shared bit pick unit
  typedef struct packed {
    logic                 hit;
    logic [NUM_W-1:0]     number;
    logic [SCAN_BITS-1:0] rest;
  } pick_t;

endpackage

// ===== hw/rtl/key_set_change_event_sequencer.sv =====
`timescale 1ns / 1ps

// an item is loaded into the scan registers, each event into the event register
// the scan tests released bits from the lowest up to the highest released one,
// then pressed bits from the highest down to the lowest pressed one
// the shared bit pick unit tests one bit per cycle, but waits while an event is stalled
// an unchanged bitmap is taken with the sequencer kept idle and gives no event
// reset: held bitmap cleared (no keys held), sequencer idle, no event valid
module key_set_change_event_sequencer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [kscs_pkg::IN_BITS-1:0] new_keys,
  input  logic [kscs_pkg::NUM_W-1:0]   base_number,
  input  logic [kscs_pkg::NUM_W-1:0]   key_group_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [kscs_pkg::NUM_W-1:0]   key_number,
  output logic [kscs_pkg::NUM_W-1:0]   key_group,
  output logic                       pressed,
  output logic                       last
);
  import kscs_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCAN_BITS - 1);

  state_t               state, state_next;
  logic [SCAN_BITS-1:0] held_keys;
  logic [SCAN_BITS-1:0] rel_vec;
  logic [SCAN_BITS-1:0] prs_vec;
  logic [IDX_W-1:0]     idx;
  logic [NUM_W-1:0]     base;
  logic [NUM_W-1:0]     group;
  logic                 out_valid_next;

  logic [SCAN_BITS-1:0] now_keys;
  logic [SCAN_BITS-1:0] rel_in;
  logic [SCAN_BITS-1:0] prs_in;
  logic                 in_xfer;
  logic [SCAN_BITS-1:0] act_vec;
  pick_t                pick;
  logic                 out_free;
  logic                 step;
  logic                 emit;
  logic [SCAN_BITS-1:0] rel_after;
  logic [SCAN_BITS-1:0] prs_after;
  logic                 emit_last;

  // incoming bitmap and its changes against the held one
  assign now_keys = new_keys[SCAN_BITS-1:0];
  assign rel_in   = held_keys & ~now_keys;
  assign prs_in   = now_keys & ~held_keys;
  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  // shared bit pick unit works on the vector of the current phase
  assign act_vec = (state == ST_PRS) ? prs_vec : rel_vec;

  kscs_pick u_pick (
    .vec  (act_vec),
    .idx  (idx),
    .base (base),
    .pick (pick)
  );

  // scan control
  always_comb begin
    out_free  = !out_valid || !out_stall;
    step      = 1'b0;
    emit      = 1'b0;
    rel_after = rel_vec;
    prs_after = prs_vec;
    case (state)
      ST_REL: begin
        step      = !pick.hit || out_free;
        emit      = pick.hit && out_free;
        rel_after = pick.rest;
      end
      ST_PRS: begin
        step      = !pick.hit || out_free;
        emit      = pick.hit && out_free;
        prs_after = pick.rest;
      end
      default: begin
      end
    endcase
    emit_last = (rel_after == '0) && (prs_after == '0);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          if (rel_in != '0) begin
            state_next = ST_REL;
          end else if (prs_in != '0) begin
            state_next = ST_PRS;
          end
        end
      end
      ST_REL: begin
        if (step && rel_after == '0) begin
          state_next = (prs_vec == '0) ? ST_IDLE : ST_PRS;
        end
      end
      ST_PRS: begin
        if (step && prs_after == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output valid holds while a pending event is stalled
  always_comb begin
    if (emit) begin
      out_valid_next = 1'b1;
    end else if (out_stall) begin
      out_valid_next = out_valid;
    end else begin
      out_valid_next = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      held_keys <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (in_xfer) begin
        held_keys <= now_keys;
      end
    end
  end

  // scan registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rel_vec <= rel_in;
      prs_vec <= prs_in;
      base    <= base_number;
      group   <= key_group_in;
      idx     <= (rel_in != '0) ? '0 : LAST_IDX;
    end else if (step) begin
      rel_vec <= rel_after;
      prs_vec <= prs_after;
      if (state == ST_REL) begin
        idx <= (rel_after == '0) ? LAST_IDX : idx + 1'b1;
      end else begin
        idx <= idx - 1'b1;
      end
    end
  end

  // event register
  always_ff @(posedge clk) begin
    if (emit) begin
      key_number <= pick.number;
      key_group  <= group;
      pressed    <= (state == ST_PRS);
      last       <= emit_last;
    end
  end

  // scan vectors only lose bits while an item is in work
  a_vec_shrink: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |=> ((rel_vec & ~$past(rel_vec)) == '0) &&
                           ((prs_vec & ~$past(prs_vec)) == '0))
    else $error("scan vector gained a bit during a scan");

  // the final event of an item returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_last) |=> (state == ST_IDLE))
    else $error("sequencer not idle after final event");

  // events of the release phase carry a clear press flag
  a_rel_flag: assert property (@(posedge clk) disable iff (rst)
    (emit && state == ST_REL) |=> (out_valid && !pressed))
    else $error("release event flagged as press");

  // reset leaves the block idle with no event pending
  a_reset: assert property (@(posedge clk)
    rst |=> (state == ST_IDLE) && !out_valid && (held_keys == '0))
    else $error("block not idle after reset");

endmodule

// ===== hw/rtl/kscs_pick.sv =====
`timescale 1ns / 1ps

module kscs_pick (
  input  logic [kscs_pkg::SCAN_BITS-1:0] vec,
  input  logic [kscs_pkg::IDX_W-1:0]     idx,
  input  logic [kscs_pkg::NUM_W-1:0]     base,
  output kscs_pkg::pick_t                pick
);
  import kscs_pkg::*;

  logic [SCAN_BITS-1:0] sel;

  // one-hot select of the scanned bit
  assign sel = {{(SCAN_BITS-1){1'b0}}, 1'b1} << idx;

  // bit test, key number and the vector with that bit cleared
  always_comb begin
    pick.hit    = |(vec & sel);
    pick.number = base + NUM_W'(idx);
    pick.rest   = vec & ~sel;
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import kscs_pkg::*;

  // one expected key event
  typedef struct packed {
    logic [NUM_W-1:0] number;
    logic [NUM_W-1:0] group;
    logic             press;
    logic             tail;
  } key_event_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [IN_BITS-1:0] new_keys = '0;
  logic [NUM_W-1:0]   base_number = '0;
  logic [NUM_W-1:0]   key_group_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [NUM_W-1:0]   key_number;
  logic [NUM_W-1:0]   key_group;
  logic               pressed;
  logic               last;

  // predictor state and expected events
  logic [IN_BITS-1:0] held_keys = '0;
  key_event_t         key_events[$];
  int                 mismatch_count = 0;
  int                 stall_left = 0;
  logic               calm = 1'b0;

  key_set_change_event_sequencer i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .new_keys    (new_keys),
    .base_number (base_number),
    .key_group_in(key_group_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .key_number  (key_number),
    .key_group   (key_group),
    .pressed     (pressed),
    .last        (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // releases ascending first, then presses descending; last flag on the final event
  function automatic void predict_events(input logic [IN_BITS-1:0] keys,
                                         input logic [NUM_W-1:0] base,
                                         input logic [NUM_W-1:0] grp);
    logic [IN_BITS-1:0] mask;
    logic [IN_BITS-1:0] now_keys;
    logic [IN_BITS-1:0] released;
    logic [IN_BITS-1:0] newly;
    int                 total;
    int                 emitted;
    key_event_t         ev;
    mask = (SCAN_BITS >= IN_BITS) ? '1 : ((IN_BITS'(1) << SCAN_BITS) - 1'b1);
    now_keys = keys & mask;
    released = held_keys & mask & ~now_keys;
    newly = now_keys & ~(held_keys & mask);
    total = $countones(released | newly);
    emitted = 0;
    for (int i = 0; i < IN_BITS; i++) begin
      if (released[i]) begin
        ev.number = base + i[NUM_W-1:0];
        ev.group = grp;
        ev.press = 1'b0;
        ev.tail = (emitted == total - 1);
        key_events.push_back(ev);
        emitted++;
      end
    end
    for (int i = IN_BITS - 1; i >= 0; i--) begin
      if (newly[i]) begin
        ev.number = base + i[NUM_W-1:0];
        ev.group = grp;
        ev.press = 1'b1;
        ev.tail = (emitted == total - 1);
        key_events.push_back(ev);
        emitted++;
      end
    end
    held_keys = now_keys;
  endfunction

  // compare one event transfer with the oldest expectation
  task automatic check_event();
    key_event_t want;
    if (key_events.size() == 0) begin
      $error("unexpected event: key_number %0d pressed %0d", key_number, pressed);
      mismatch_count++;
    end else begin
      want = key_events.pop_front();
      if (key_number !== want.number) begin
        $error("key_number: expected %0d, got %0d", want.number, key_number);
        mismatch_count++;
      end
      if (key_group !== want.group) begin
        $error("key_group: expected %0d, got %0d", want.group, key_group);
        mismatch_count++;
      end
      if (pressed !== want.press) begin
        $error("pressed: expected %0d, got %0d", want.press, pressed);
        mismatch_count++;
      end
      if (last !== want.tail) begin
        $error("last: expected %0d, got %0d", want.tail, last);
        mismatch_count++;
      end
    end
  endtask

  // output side: check transfers, stall at random
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_event();
    if (calm) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  // one scan transfer, preceded by a random idle gap
  task automatic send_keys(input logic [IN_BITS-1:0] keys, input logic [NUM_W-1:0] base,
                           input logic [NUM_W-1:0] grp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    new_keys <= keys;
    base_number <= base;
    key_group_in <= grp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_events(keys, base, grp);
  endtask

  task automatic test_single_keys();
    send_keys(32'h0000_0001, 8'h00, 8'h00);
    send_keys(32'h0000_0000, 8'h00, 8'h00);
    send_keys(32'h8000_0000, 8'h00, 8'hFF);
    send_keys(32'h0000_0000, 8'h7F, 8'hFF);
  endtask

  // every key pressed at once, then all released
  task automatic test_full_bitmap();
    send_keys(32'hFFFF_FFFF, 8'h10, 8'hA5);
    send_keys(32'h0000_0000, 8'h10, 8'h5A);
    send_keys(32'hFFFF_FFFF, 8'hEF, 8'h01);
    send_keys(32'h0000_0000, 8'h00, 8'h80);
  endtask

  // base plus bit index past 255 wraps around
  task automatic test_key_number_wrap();
    send_keys(32'h0000_0003, 8'hFF, 8'h33);
    send_keys(32'hC000_0000, 8'hE5, 8'hCC);
    send_keys(32'h0000_0000, 8'hFF, 8'h00);
  endtask

  // same bitmap again gives no event, whatever base and group say
  task automatic test_unchanged_bitmap();
    send_keys(32'h1234_5678, 8'h20, 8'h11);
    send_keys(32'h1234_5678, 8'h99, 8'h22);
    send_keys(32'h1234_5678, 8'h00, 8'hFF);
    send_keys(32'h1234_5679, 8'h40, 8'h44);
  endtask

  // releases and presses in one item
  task automatic test_mixed_changes();
    send_keys(32'hAAAA_AAAA, 8'h01, 8'h0F);
    send_keys(32'h5555_5555, 8'hF0, 8'hF0);
    send_keys(32'hD555_5554, 8'h80, 8'h3C);
    send_keys(32'h0000_0000, 8'h08, 8'hC3);
  endtask

  // mostly a few keys changing per scan, with whole-bitmap jumps mixed in
  task automatic test_random_scans(input int count);
    logic [IN_BITS-1:0] scan_keys;
    int                 r;
    scan_keys = held_keys;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        repeat ($urandom_range(1, 4)) scan_keys[$urandom_range(0, IN_BITS - 1)] ^= 1'b1;
      end else if (r < 70) begin
        scan_keys = $urandom;
      end else if (r < 78) begin
        scan_keys = scan_keys;
      end else if (r < 84) begin
        scan_keys = '0;
      end else if (r < 90) begin
        scan_keys = '1;
      end else begin
        scan_keys = $urandom & $urandom;
      end
      send_keys(scan_keys, NUM_W'($urandom), NUM_W'($urandom));
    end
  endtask

  // no gaps on either side
  task automatic test_back_to_back(input int count);
    calm <= 1'b1;
    test_random_scans(count);
    calm <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_single_keys();
    test_full_bitmap();
    test_key_number_wrap();
    test_unchanged_bitmap();
    test_mixed_changes();
    test_random_scans(240);
    test_back_to_back(50);
    test_random_scans(10);
    in_valid <= 1'b0;
    while (key_events.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/kscs_pkg.sv
hw/rtl/kscs_pick.sv
hw/rtl/key_set_change_event_sequencer.sv
tb/testbench.sv
